// ----- rtl/aqs_pkg.sv -----
// ----------------------------------------------------------------------------
// aqs_pkg: shared types, constants and trig table builder
// Holds the sequencer state type, field widths and the elaboration-time
// builder for the cosine and sine tables used by the arc tessellator.
// ----------------------------------------------------------------------------
package aqs_pkg;

  // Field widths
  localparam int COORD_W    = 10;
  localparam int ANGLE_W    = 9;
  localparam int VERT_W     = 12;
  localparam int RADIUS_W   = COORD_W + 1;
  localparam int TRIG_MAX_W = 18;

  // Angle constants in degrees
  localparam int DEG_FULL   = 360;
  localparam int IDX_OFFSET = 270;
  localparam int SPAN_MAX   = 360;
  localparam int TAB_DEPTH  = 360;

  // Defaults for the top-level parameters
  localparam int SEGMENT_DEGREES_DEF    = 6;
  localparam int TRIG_FRACTION_BITS_DEF = 15;

  // Stream payload widths, padded to whole bytes
  localparam int IN_BITS   = 4 * COORD_W + 2 * ANGLE_W + COORD_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 8 * VERT_W;

  // Table builder constants (Q40 step and quarter turn, Q30 one)
  localparam longint DEG_STEP_Q40 = 64'sd19189446586;
  localparam longint HALF_PI_Q40  = 64'sd1727108826179;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam longint CDIV [6] = '{64'sd132, 64'sd90, 64'sd56, 64'sd30, 64'sd12, 64'sd2};
  localparam longint SDIV [6] = '{64'sd156, 64'sd110, 64'sd72, 64'sd42, 64'sd20, 64'sd6};

  typedef logic signed [TRIG_MAX_W-1:0] trig_rom_t [TAB_DEPTH];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROM,
    ST_MUL,
    ST_ADV,
    ST_OUT
  } aqs_state_e;

  // Build one trig table at elaboration: Taylor series after quarter-turn
  // reduction, rounded half away from zero to frac_bits fraction bits.
  function automatic trig_rom_t build_trig(int frac_bits, bit want_sin);
    trig_rom_t tab;
    longint theta;
    longint q;
    longint rem;
    longint m;
    longint x2;
    longint c;
    longint s;
    longint sr;
    longint cv;
    longint sv;
    longint val;
    longint mag;
    bit     neg;
    bit     vneg;
    for (int k = 0; k < TAB_DEPTH; k++) begin
      theta = longint'(k) * DEG_STEP_Q40;
      q     = (theta + HALF_PI_Q40 / 2) / HALF_PI_Q40;
      rem   = theta - q * HALF_PI_Q40;
      neg   = (rem < 0);
      m     = (neg ? -rem : rem) >>> 10;
      x2    = (m * m) >>> 30;
      c     = ONE_Q30;
      s     = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
        c = ONE_Q30 - ((x2 * c) >>> 30) / CDIV[i];
        s = ONE_Q30 - ((x2 * s) >>> 30) / SDIV[i];
      end
      s  = (m * s) >>> 30;
      sr = neg ? -s : s;
      case (q & 64'sd3)
        64'sd0:  begin cv = c;   sv = sr;  end
        64'sd1:  begin cv = -sr; sv = c;   end
        64'sd2:  begin cv = -c;  sv = -sr; end
        default: begin cv = sr;  sv = -c;  end
      endcase
      val  = want_sin ? sv : cv;
      vneg = (val < 0);
      mag  = vneg ? -val : val;
      mag  = (mag + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
      val  = vneg ? -mag : mag;
      tab[k] = TRIG_MAX_W'(val);
    end
    return tab;
  endfunction

endpackage

// ----- rtl/arc_to_quad_segments.sv -----
// ----------------------------------------------------------------------------
// arc_to_quad_segments: thick elliptical arc tessellator
// Cuts one arc request into quads of SEGMENT_DEGREES each and streams out
// the inner and outer vertices at every segment's start and end.
// ----------------------------------------------------------------------------
// One request is taken when the block is idle; it then emits span/SEGMENT_DEGREES
// quads (span capped at 360) and flags the last with tlast, or none at all when
// the span is shorter than one segment. A single multiplier computes the four
// vertices of an angle one after another, after one registered read of the
// cos/sin table; a stall on the output side holds the quad in progress. The last
// quad waits in the output register, so the next request is taken meanwhile.
module arc_to_quad_segments #(
  parameter int SEGMENT_DEGREES    = aqs_pkg::SEGMENT_DEGREES_DEF,
  parameter int TRIG_FRACTION_BITS = aqs_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // center_x, center_y, start_deg, span_degrees, radius_x, radius_y,
  // thickness, zero fill
  input  logic [aqs_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // inner_start_x, inner_start_y, outer_start_x, outer_start_y,
  // inner_end_x, inner_end_y, outer_end_x, outer_end_y
  output logic [aqs_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);
  import aqs_pkg::*;

  localparam int TrigW = TRIG_FRACTION_BITS + 2;
  localparam logic [ANGLE_W-1:0] SegDeg   = ANGLE_W'(SEGMENT_DEGREES);
  localparam logic [ANGLE_W-1:0] SegTwice = ANGLE_W'(2 * SEGMENT_DEGREES);
  localparam logic [ANGLE_W-1:0] DegFull  = ANGLE_W'(DEG_FULL);
  localparam logic [ANGLE_W-1:0] SpanMax  = ANGLE_W'(SPAN_MAX);
  localparam logic [ANGLE_W:0]   IdxOff   = (ANGLE_W + 1)'(IDX_OFFSET);
  localparam logic [ANGLE_W:0]   IdxWrap  = (ANGLE_W + 1)'(DEG_FULL);
  localparam trig_rom_t CosRom = build_trig(TRIG_FRACTION_BITS, 1'b0);
  localparam trig_rom_t SinRom = build_trig(TRIG_FRACTION_BITS, 1'b1);

  // Input field slices
  localparam int CxLo = 0;
  localparam int CyLo = CxLo + COORD_W;
  localparam int StLo = CyLo + COORD_W;
  localparam int SpLo = StLo + ANGLE_W;
  localparam int RxLo = SpLo + ANGLE_W;
  localparam int RyLo = RxLo + COORD_W;
  localparam int ThLo = RyLo + COORD_W;

  aqs_state_e state_q, state_d;
  logic [2:0] step_q;
  logic       first_q;
  logic       out_valid_q;
  logic       out_last_q;

  logic [COORD_W-1:0] cx_q, cy_q, rx_q, ry_q, th_q;
  logic [ANGLE_W-1:0] angle_q;
  logic [ANGLE_W-1:0] rem_q;
  logic signed [TrigW-1:0]  cos_q, sin_q;
  logic signed [VERT_W-1:0] prev_q [4];
  logic signed [VERT_W-1:0] end_q [4];
  logic [OUT_DATA_W-1:0]    out_data_q;

  logic               in_fire;
  logic [ANGLE_W-1:0] in_start;
  logic [ANGLE_W-1:0] in_span;
  logic [ANGLE_W-1:0] span_clamp;
  logic [ANGLE_W-1:0] start_wrap;
  logic [ANGLE_W:0]   idx_sum;
  logic [ANGLE_W-1:0] tab_idx;
  logic [ANGLE_W:0]   angle_sum;
  logic [ANGLE_W-1:0] angle_next;
  logic               out_free;
  logic               issue;
  logic [1:0]         sel;
  logic signed [TrigW-1:0]    mul_trig;
  logic signed [RADIUS_W-1:0] mul_radius;
  logic [COORD_W-1:0]         mul_centre;
  logic signed [VERT_W-1:0]   vertex;
  logic [1:0]                 wr_sel;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign in_start   = s_axis_tdata[StLo +: ANGLE_W];
  assign in_span    = s_axis_tdata[SpLo +: ANGLE_W];
  assign span_clamp = (in_span > SpanMax) ? SpanMax : in_span;
  assign start_wrap = (in_start >= DegFull) ? (in_start - DegFull) : in_start;

  // Table index for (angle - 90) and the next segment angle
  assign idx_sum    = {1'b0, angle_q} + IdxOff;
  assign tab_idx    = (idx_sum >= IdxWrap) ? ANGLE_W'(idx_sum - IdxWrap) : ANGLE_W'(idx_sum);
  assign angle_sum  = {1'b0, angle_q} + {1'b0, SegDeg};
  assign angle_next = (angle_sum >= IdxWrap) ? ANGLE_W'(angle_sum - IdxWrap)
                                             : ANGLE_W'(angle_sum);
  assign out_free   = !out_valid_q || m_axis_tready;

  // Operand select: inner x, inner y, outer x, outer y
  assign issue  = (state_q == ST_MUL) && !step_q[2];
  assign sel    = step_q[1:0];
  assign wr_sel = 2'(step_q - 3'd1);
  always_comb begin
    mul_trig   = sel[0] ? sin_q : cos_q;
    mul_centre = sel[0] ? cy_q : cx_q;
    case (sel)
      2'd0:    mul_radius = RADIUS_W'({1'b0, rx_q}) - RADIUS_W'({1'b0, th_q});
      2'd1:    mul_radius = RADIUS_W'({1'b0, ry_q}) - RADIUS_W'({1'b0, th_q});
      2'd2:    mul_radius = RADIUS_W'({1'b0, rx_q});
      default: mul_radius = RADIUS_W'({1'b0, ry_q});
    endcase
  end

  aqs_vertex_unit #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_vertex (
    .clk_i    (clk_i),
    .issue_i  (issue),
    .trig_i   (mul_trig),
    .radius_i (mul_radius),
    .centre_i (mul_centre),
    .vertex_o (vertex)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (span_clamp >= SegDeg)) state_d = ST_ROM;
      end
      ST_ROM:  state_d = ST_MUL;
      ST_MUL: begin
        if (step_q[2]) state_d = first_q ? ST_ADV : ST_OUT;
      end
      ST_ADV:  state_d = ST_ROM;
      ST_OUT: begin
        if (out_free) state_d = (rem_q < SegTwice) ? ST_IDLE : ST_ADV;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_MUL) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
      if (in_fire) begin
        first_q <= 1'b1;
      end else if (state_q == ST_ADV) begin
        first_q <= 1'b0;
      end
      if ((state_q == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request, angle, table read and vertex registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cx_q    <= s_axis_tdata[CxLo +: COORD_W];
      cy_q    <= s_axis_tdata[CyLo +: COORD_W];
      rx_q    <= s_axis_tdata[RxLo +: COORD_W];
      ry_q    <= s_axis_tdata[RyLo +: COORD_W];
      th_q    <= s_axis_tdata[ThLo +: COORD_W];
      angle_q <= start_wrap;
      rem_q   <= span_clamp;
    end
    if (state_q == ST_ROM) begin
      cos_q <= TrigW'(CosRom[tab_idx]);
      sin_q <= TrigW'(SinRom[tab_idx]);
    end
    if ((state_q == ST_MUL) && (step_q != 3'd0)) begin
      end_q[wr_sel] <= vertex;
    end
    if (state_q == ST_ADV) begin
      angle_q <= angle_next;
      if (first_q) begin
        for (int j = 0; j < 4; j++) prev_q[j] <= end_q[j];
      end
    end
    if ((state_q == ST_OUT) && out_free) begin
      out_data_q <= {end_q[3], end_q[2], end_q[1], end_q[0],
                     prev_q[3], prev_q[2], prev_q[1], prev_q[0]};
      out_last_q <= (rem_q < SegTwice);
      rem_q      <= rem_q - SegDeg;
      for (int j = 0; j < 4; j++) prev_q[j] <= end_q[j];
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tvalid = out_valid_q;

endmodule

// ----- rtl/aqs_vertex_unit.sv -----
// ----------------------------------------------------------------------------
// aqs_vertex_unit: shared vertex multiplier
// Multiplies a trig value by a radius and registers the product, then
// truncates toward zero, adds the centre and saturates to a signed vertex.
// ----------------------------------------------------------------------------
module aqs_vertex_unit #(
  parameter int TRIG_FRACTION_BITS = aqs_pkg::TRIG_FRACTION_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         issue_i,
  input  logic signed [TRIG_FRACTION_BITS+1:0]         trig_i,
  input  logic signed [aqs_pkg::RADIUS_W-1:0]          radius_i,
  input  logic        [aqs_pkg::COORD_W-1:0]           centre_i,
  output logic signed [aqs_pkg::VERT_W-1:0]            vertex_o
);
  import aqs_pkg::*;

  localparam int TrigW = TRIG_FRACTION_BITS + 2;
  localparam int ProdW = TrigW + RADIUS_W;
  localparam int SumW  = VERT_W + 1;
  localparam logic signed [ProdW-1:0] RoundBias = ProdW'((64'sd1 <<< TRIG_FRACTION_BITS) - 1);
  localparam logic signed [SumW-1:0]  VertMax   = SumW'(2047);
  localparam logic signed [SumW-1:0]  VertMin   = -SumW'(2048);

  logic signed [ProdW-1:0]   prod_q;
  logic        [COORD_W-1:0] centre_q;
  logic signed [ProdW-1:0]   biased;
  logic signed [ProdW-1:0]   shifted;
  logic signed [SumW-1:0]    sum;

  // Register the product and its centre
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      prod_q   <= ProdW'(trig_i) * ProdW'(radius_i);
      centre_q <= centre_i;
    end
  end

  // Truncate toward zero, add the centre, saturate
  always_comb begin
    biased  = prod_q[ProdW-1] ? (prod_q + RoundBias) : prod_q;
    shifted = biased >>> TRIG_FRACTION_BITS;
    sum     = SumW'(shifted) + SumW'({1'b0, centre_q});
    if (sum > VertMax) begin
      vertex_o = VERT_W'(VertMax);
    end else if (sum < VertMin) begin
      vertex_o = VERT_W'(VertMin);
    end else begin
      vertex_o = VERT_W'(sum);
    end
  end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for arc_to_quad_segments
// Streams arc requests into the tessellator and predicts every quad from a
// local trig table and vertex model. Each quad that leaves the block is checked
// field by field, including the last-quad flag. Both stream sides idle at
// random. The output side holds off once for a long stretch, and the input
// side pauses once until every expected quad has drained.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_DEG     = 6;
  localparam int FRAC_BITS   = 15;
  localparam int QUAD_CAP    = 60;
  localparam int ITEM_COUNT  = 460;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 600;
  localparam int REPORT_MAX  = 10;

  localparam longint STEP_Q40    = 64'sd19189446586;
  localparam longint HALF_PI_Q40 = 64'sd1727108826179;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef struct {
    logic [9:0] cx;
    logic [9:0] cy;
    logic [8:0] start;
    logic [8:0] span;
    logic [9:0] rx;
    logic [9:0] ry;
    logic [9:0] thick;
    bit         wait_drain;
  } arc_req_t;

  // vtx: inner/outer x/y at segment start (0..3), then at segment end (4..7)
  typedef struct packed {
    logic            last;
    logic [7:0][11:0] vtx;
  } quad_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic [aqs_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [aqs_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;

  arc_to_quad_segments #(
    .SEGMENT_DEGREES   (SEG_DEG),
    .TRIG_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // Trig tables and tessellator state mirrored by the predictor
  int cos_lut [360];
  int sin_lut [360];
  int arc_angle;
  int quads_left;
  int lat_cx, lat_cy, lat_rx, lat_ry, lat_w, lat_span;
  logic [3:0][11:0] prev_vtx;

  arc_req_t pending_arcs[$];
  quad_t    expected_quads[$];
  arc_req_t offered_arc;

  int  arcs_accepted = 0;
  int  cycle_count = 0;
  int  mismatches = 0;
  int  send_gap;
  int  recv_stall;
  int  holdoff_left;
  bit  holdoff_done;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Append to the tail of the request and expected-quad queues
  function automatic void add_arc(arc_req_t a);
    pending_arcs.insert(pending_arcs.size(), a);
  endfunction

  function automatic void add_quad(quad_t q);
    expected_quads.insert(expected_quads.size(), q);
  endfunction

  // Round half away from zero from Q30 to FRAC_BITS fraction bits
  function automatic int round_to_frac(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    return int'((v < 0) ? -mag : mag);
  endfunction

  // Taylor series after reduction to the nearest quarter turn
  function automatic void build_trig_luts();
    longint theta, quad, rem, mag, x2, c, s, sr, cv, sv;
    int     n;
    bit     neg;
    for (int k = 0; k < 360; k++) begin
      theta = longint'(k) * STEP_Q40;
      quad  = (theta + HALF_PI_Q40 / 2) / HALF_PI_Q40;
      rem   = theta - quad * HALF_PI_Q40;
      neg   = (rem < 0);
      mag   = (neg ? -rem : rem) >>> 10;
      x2    = (mag * mag) >>> 30;
      c     = ONE_Q30;
      s     = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
        n = 12 - 2 * i;
        c = ONE_Q30 - ((x2 * c) >>> 30) / longint'(n * (n - 1));
        s = ONE_Q30 - ((x2 * s) >>> 30) / longint'((n + 1) * n);
      end
      s  = (mag * s) >>> 30;
      sr = neg ? -s : s;
      case (quad % 4)
        0: begin
          cv = c;   sv = sr;
        end
        1: begin
          cv = -sr; sv = c;
        end
        2: begin
          cv = -c;  sv = -sr;
        end
        default: begin
          cv = sr;  sv = -c;
        end
      endcase
      cos_lut[k] = round_to_frac(cv);
      sin_lut[k] = round_to_frac(sv);
    end
  endfunction

  // Scale by the trig value with truncation toward zero, then saturate
  function automatic logic [11:0] place_vertex(int centre, int trig, int radius);
    longint prod, mag, v;
    prod = longint'(trig) * longint'(radius);
    mag  = ((prod < 0) ? -prod : prod) >>> FRAC_BITS;
    v    = longint'(centre) + ((prod < 0) ? -mag : mag);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[11:0];
  endfunction

  // Inner x, inner y, outer x, outer y at one angle; zero degrees points up
  function automatic logic [3:0][11:0] ring_vertices(int deg);
    logic [3:0][11:0] r;
    int idx;
    idx  = (deg + 270) % 360;
    r[0] = place_vertex(lat_cx, cos_lut[idx], lat_rx - lat_w);
    r[1] = place_vertex(lat_cy, sin_lut[idx], lat_ry - lat_w);
    r[2] = place_vertex(lat_cx, cos_lut[idx], lat_rx);
    r[3] = place_vertex(lat_cy, sin_lut[idx], lat_ry);
    return r;
  endfunction

  // Latch one request and queue the quads it should produce
  function automatic void predict_quads(arc_req_t a);
    logic [3:0][11:0] end_v;
    quad_t q;
    int    count;
    lat_span  = (a.span > 360) ? 360 : int'(a.span);
    lat_cx    = int'(a.cx);
    lat_cy    = int'(a.cy);
    lat_rx    = int'(a.rx);
    lat_ry    = int'(a.ry);
    lat_w     = int'(a.thick);
    arc_angle = int'(a.start) % 360;
    count     = lat_span / SEG_DEG;
    if (count > QUAD_CAP) count = QUAD_CAP;
    quads_left = count;
    if (count == 0) return;
    prev_vtx = ring_vertices(arc_angle);
    for (int k = 0; k < count; k++) begin
      arc_angle = (arc_angle + SEG_DEG) % 360;
      end_v     = ring_vertices(arc_angle);
      q.vtx     = {end_v, prev_vtx};
      q.last    = (k == count - 1);
      add_quad(q);
      prev_vtx  = end_v;
      quads_left--;
    end
  endfunction

  function automatic arc_req_t make_arc(int cx, int cy, int st, int sp,
                                        int rx, int ry, int th);
    arc_req_t a;
    a.cx = 10'(cx); a.cy = 10'(cy); a.start = 9'(st); a.span = 9'(sp);
    a.rx = 10'(rx); a.ry = 10'(ry); a.thick = 10'(th);
    a.wait_drain = 1'b0;
    return a;
  endfunction

  // Mostly short arcs, some long ones, a few near or beyond a full turn
  function automatic arc_req_t random_arc();
    arc_req_t a;
    int sel;
    a.cx    = 10'($urandom_range(0, 1023));
    a.cy    = 10'($urandom_range(0, 1023));
    a.start = 9'($urandom_range(0, 511));
    sel     = int'($urandom_range(0, 9));
    if (sel < 7) a.span = 9'($urandom_range(0, 120));
    else if (sel < 9) a.span = 9'($urandom_range(0, 511));
    else a.span = 9'($urandom_range(340, 511));
    a.rx = 10'($urandom_range(0, 1023));
    a.ry = 10'($urandom_range(0, 1023));
    if ($urandom_range(0, 9) < 7)
      a.thick = 10'($urandom_range(0, int'((a.rx < a.ry) ? a.rx : a.ry)));
    else
      a.thick = 10'($urandom_range(0, 1023));
    a.wait_drain = 1'b0;
    return a;
  endfunction

  function automatic logic [aqs_pkg::IN_DATA_W-1:0] pack_arc(arc_req_t a);
    return aqs_pkg::IN_DATA_W'({a.thick, a.ry, a.rx, a.span, a.start, a.cy, a.cx});
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
  endfunction

  // Random idling only in alternate stretches, and never near the end
  function automatic bit idling_allowed();
    return (pending_arcs.size() > 60) && cycle_count[9];
  endfunction

  // Run-time cap
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Request driver: hold an offer until its transfer, then pick the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_quads(offered_arc);
        arcs_accepted <= arcs_accepted + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // keep offering the same request
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_arcs.size() != 0 &&
                   !(pending_arcs[0].wait_drain && expected_quads.size() != 0)) begin
        offered_arc = pending_arcs.pop_front();
        s_axis_tdata  <= pack_arc(offered_arc);
        s_axis_tvalid <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 3) == 0)
          send_gap = int'($urandom_range(1, 5));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Quad receiver: short random stalls and one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall   = 0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
    end else begin
      if (!holdoff_done && arcs_accepted >= 100) begin
        holdoff_left = 500;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (idling_allowed() && $urandom_range(0, 4) == 0)
          recv_stall = int'($urandom_range(1, 5));
      end
    end
  end

  // Quad checker: compare each transfer with the oldest expected quad
  always @(posedge clk_i) begin
    quad_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_quads.size() == 0) begin
        note_failure($sformatf("quad with none expected: data=%h last=%b",
                               m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_quads.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (m_axis_tdata[12*i +: 12] !== want.vtx[i])
            note_failure($sformatf("vertex field %0d: expected %0d, got %0d", i,
                                   $signed(want.vtx[i]),
                                   $signed(m_axis_tdata[12*i +: 12])));
        end
        if (m_axis_tlast !== want.last)
          note_failure($sformatf("last flag: expected %b, got %b",
                                 want.last, m_axis_tlast));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    build_trig_luts();
    // short spans, single quads, full and oversized turns
    add_arc(make_arc(512, 512, 0, 0, 100, 100, 10));
    add_arc(make_arc(512, 512, 0, 5, 100, 100, 10));
    add_arc(make_arc(0, 0, 0, 6, 1023, 1023, 0));
    add_arc(make_arc(1023, 1023, 359, 7, 1023, 1023, 1023));
    add_arc(make_arc(1023, 0, 90, 360, 1023, 1023, 0));
    add_arc(make_arc(0, 1023, 180, 511, 500, 300, 20));
    // start angles at and beyond a full turn, wrap through zero
    add_arc(make_arc(300, 700, 360, 12, 200, 400, 50));
    add_arc(make_arc(700, 300, 511, 30, 400, 200, 60));
    add_arc(make_arc(512, 512, 354, 12, 800, 800, 100));
    // thickness above the radius mirrors the inner ring
    add_arc(make_arc(512, 512, 270, 361, 600, 100, 900));
    add_arc(make_arc(512, 512, 45, 90, 0, 0, 0));
    add_arc(make_arc(512, 512, 0, 120, 0, 0, 1023));
    add_arc(make_arc(100, 900, 300, 359, 1023, 0, 512));
    add_arc(make_arc(0, 0, 0, 0, 0, 0, 0));
    add_arc(make_arc(1023, 1023, 511, 511, 1023, 1023, 1023));
    while (pending_arcs.size() < ITEM_COUNT)
      add_arc(random_arc());
    // let everything drain once mid-run
    pending_arcs[250].wait_drain = 1'b1;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_arcs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_quads.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
